/* rtl/core/sia_pkg.sv */
// Shared types, operation codes and helpers for the shader integer ALU.
// No dependencies; used by sia_div and shader_integer_alu.
`default_nettype none
package sia_pkg;

    localparam int DATA_W   = 64;
    localparam int DIV_STEPS = 64;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_MUL  = 5'd2;
    localparam logic [4:0] OP_UDIV = 5'd3;
    localparam logic [4:0] OP_UMOD = 5'd4;
    localparam logic [4:0] OP_SDIV = 5'd5;
    localparam logic [4:0] OP_SREM = 5'd6;
    localparam logic [4:0] OP_AND  = 5'd7;
    localparam logic [4:0] OP_OR   = 5'd8;
    localparam logic [4:0] OP_XOR  = 5'd9;
    localparam logic [4:0] OP_NOT  = 5'd10;
    localparam logic [4:0] OP_NEG  = 5'd11;
    localparam logic [4:0] OP_SHL  = 5'd12;
    localparam logic [4:0] OP_SHRL = 5'd13;
    localparam logic [4:0] OP_SHRA = 5'd14;
    localparam logic [4:0] OP_EQ   = 5'd15;
    localparam logic [4:0] OP_NE   = 5'd16;
    localparam logic [4:0] OP_UGT  = 5'd17;
    localparam logic [4:0] OP_UGE  = 5'd18;
    localparam logic [4:0] OP_ULT  = 5'd19;
    localparam logic [4:0] OP_ULE  = 5'd20;
    localparam logic [4:0] OP_SGT  = 5'd21;
    localparam logic [4:0] OP_SGE  = 5'd22;
    localparam logic [4:0] OP_SLT  = 5'd23;

    localparam logic [1:0] W16 = 2'd0;
    localparam logic [1:0] W32 = 2'd1;

    // Sideband carried alongside the divider
    typedef struct packed {
        logic              div_op;   // result comes from the divider
        logic              rem_sel;  // take remainder, not quotient
        logic              neg;      // negate divider result
        logic              dz;       // divide by zero
        logic [1:0]        wsel;
        logic [DATA_W-1:0] res;      // result of every other op
    } t_side;

    function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] wsel);
        logic [DATA_W-1:0] m;
        unique case (wsel)
            W16:     m = {{(DATA_W-16){1'b0}}, {16{1'b1}}};
            W32:     m = {{(DATA_W-32){1'b0}}, {32{1'b1}}};
            default: m = {DATA_W{1'b1}};
        endcase
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] width_bits(input logic [1:0] wsel);
        logic [DATA_W-1:0] n;
        unique case (wsel)
            W16:     n = DATA_W'(16);
            W32:     n = DATA_W'(32);
            default: n = DATA_W'(64);
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/sia_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on sia_pkg.
`default_nettype none
module sia_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [sia_pkg::DATA_W-1:0] i_dividend,
    input  wire logic [sia_pkg::DATA_W-1:0] i_divisor,
    input  wire sia_pkg::t_side        i_side,
    output logic                       o_valid,
    output logic [sia_pkg::DATA_W-1:0] o_quo,
    output logic [sia_pkg::DATA_W-1:0] o_rem,
    output sia_pkg::t_side             o_side
);
    import sia_pkg::*;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        // previous stage (or the divider inputs for the first one)
        logic              p_vld;
        logic [DATA_W-1:0] p_rem, p_quo, p_dvs;
        t_side             p_side;
        // this stage
        logic              r_vld;
        logic [DATA_W-1:0] r_rem, r_quo, r_dvs;
        t_side             r_side;
        logic [DATA_W:0]   n_trial;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_quo  = i_dividend;
            assign p_dvs  = i_divisor;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = g_step[k-1].r_vld;
            assign p_rem  = g_step[k-1].r_rem;
            assign p_quo  = g_step[k-1].r_quo;
            assign p_dvs  = g_step[k-1].r_dvs;
            assign p_side = g_step[k-1].r_side;
        end

        assign n_trial = {p_rem, p_quo[DATA_W-1]} - {1'b0, p_dvs};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= p_vld;
            end
            if (!n_trial[DATA_W]) begin
                r_rem <= n_trial[DATA_W-1:0];
                r_quo <= {p_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= {p_rem[DATA_W-2:0], p_quo[DATA_W-1]};
                r_quo <= {p_quo[DATA_W-2:0], 1'b0};
            end
            r_dvs  <= p_dvs;
            r_side <= p_side;
        end
    end

    assign o_valid = g_step[DIV_STEPS-1].r_vld;
    assign o_quo   = g_step[DIV_STEPS-1].r_quo;
    assign o_rem   = g_step[DIV_STEPS-1].r_rem;
    assign o_side  = g_step[DIV_STEPS-1].r_side;
endmodule
`default_nettype wire

/* rtl/core/shader_integer_alu.sv */
// Top level of the shader integer ALU: decode, multiply, divide, select.
// Depends on sia_pkg and sia_div.
`default_nettype none
// Fully pipelined scalar integer unit. A request is taken on every cycle that
// i_start is high (o_busy is always low), and its result is shown on o_result
// and o_div_by_zero for exactly one cycle, marked by o_valid, after passing through
// one input register, one operand/partial-product stage, one product-merge
// stage, 64 divider stages (one quotient bit each) and an output register.
// Every operation takes the same path, so results leave in request order.
// The receiver cannot stall the unit.
module shader_integer_alu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [4:0]  i_op,
    input  wire logic [1:0]  i_width_sel,
    input  wire logic        i_signed_le,
    input  wire logic [63:0] i_operand_a,
    input  wire logic [63:0] i_operand_b,
    output logic             o_valid,
    output logic [63:0]      o_result,
    output logic             o_div_by_zero
);
    import sia_pkg::*;

    // Stage 0: request register
    logic              r0_vld;
    logic [4:0]        r0_op;
    logic [1:0]        r0_wsel;
    logic              r0_le;
    logic [DATA_W-1:0] r0_a, r0_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= i_start;
        end
        r0_op   <= i_op;
        r0_wsel <= i_width_sel;
        r0_le   <= i_signed_le;
        r0_a    <= i_operand_a;
        r0_b    <= i_operand_b;
    end

    assign o_busy = 1'b0;

    // Stage 1: masking, sign extension, simple ops, partial products
    logic [DATA_W-1:0] n_mask, n_a, n_b, n_sa, n_sb, n_ua, n_ub, n_res, n_w;
    logic              n_an, n_bn, n_big, n_bz;
    logic [5:0]        n_sh;
    logic [DATA_W-1:0] n_dvd, n_dvs;
    t_side             n_side;

    always_comb begin
        n_mask = width_mask(r0_wsel);
        n_w    = width_bits(r0_wsel);
        n_a    = r0_a & n_mask;
        n_b    = r0_b & n_mask;
        n_an   = |(n_a & ~(n_mask >> 1));
        n_bn   = |(n_b & ~(n_mask >> 1));
        n_sa   = n_an ? (n_a | ~n_mask) : n_a;
        n_sb   = n_bn ? (n_b | ~n_mask) : n_b;
        n_ua   = n_an ? (DATA_W'(0) - n_sa) : n_sa;
        n_ub   = n_bn ? (DATA_W'(0) - n_sb) : n_sb;
        n_big  = n_b >= n_w;
        n_bz   = (n_b == '0);
        n_sh   = n_b[5:0];
        n_res  = '0;
        case (r0_op)
            OP_ADD:  n_res = n_a + n_b;
            OP_SUB:  n_res = n_a - n_b;
            OP_AND:  n_res = n_a & n_b;
            OP_OR:   n_res = n_a | n_b;
            OP_XOR:  n_res = n_a ^ n_b;
            OP_NOT:  n_res = ~n_a;
            OP_NEG:  n_res = DATA_W'(0) - n_a;
            OP_SHL:  n_res = n_big ? '0 : (n_a << n_sh);
            OP_SHRL: n_res = n_big ? '0 : (n_a >> n_sh);
            OP_SHRA: n_res = n_big ? (n_an ? n_mask : '0)
                                   : DATA_W'($signed(n_sa) >>> n_sh);
            OP_EQ:   n_res = DATA_W'(n_a == n_b);
            OP_NE:   n_res = DATA_W'(n_a != n_b);
            OP_UGT:  n_res = DATA_W'(n_a > n_b);
            OP_UGE:  n_res = DATA_W'(n_a >= n_b);
            OP_ULT:  n_res = DATA_W'(n_a < n_b);
            OP_ULE:  n_res = DATA_W'(n_a <= n_b);
            OP_SGT:  n_res = DATA_W'($signed(n_sa) > $signed(n_sb));
            OP_SGE:  n_res = DATA_W'($signed(n_sa) >= $signed(n_sb));
            OP_SLT:  n_res = r0_le ? DATA_W'($signed(n_sa) <= $signed(n_sb))
                                   : DATA_W'($signed(n_sa) < $signed(n_sb));
            default: n_res = '0;
        endcase

        n_side        = '0;
        n_side.wsel   = r0_wsel;
        n_side.res    = n_res;
        n_dvd         = n_a;
        n_dvs         = n_b;
        case (r0_op)
            OP_UDIV, OP_UMOD: begin
                n_side.div_op  = 1'b1;
                n_side.rem_sel = (r0_op == OP_UMOD);
                n_side.dz      = n_bz;
            end
            OP_SDIV: begin
                n_side.div_op = 1'b1;
                n_side.neg    = n_an ^ n_bn;
                n_side.dz     = n_bz;
                n_dvd         = n_ua;
                n_dvs         = n_ub;
            end
            OP_SREM: begin
                n_side.div_op  = 1'b1;
                n_side.rem_sel = 1'b1;
                n_side.neg     = n_an;
                n_side.dz      = n_bz;
                n_dvd          = n_ua;
                n_dvs          = n_ub;
            end
            default: ;
        endcase
    end

    logic              r1_vld, r1_mul;
    logic [DATA_W-1:0] r1_dvd, r1_dvs;
    logic [63:0]       r1_p0;
    logic [31:0]       r1_p1, r1_p2;
    t_side             r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= r0_vld;
        end
        r1_mul  <= (r0_op == OP_MUL);
        r1_dvd  <= n_dvd;
        r1_dvs  <= n_dvs;
        r1_side <= n_side;
        // low 64 bits of the product only need three 32x32 products
        r1_p0   <= n_a[31:0] * n_b[31:0];
        r1_p1   <= 32'(n_a[31:0] * n_b[63:32]);
        r1_p2   <= 32'(n_a[63:32] * n_b[31:0]);
    end

    // Stage 2: merge partial products
    logic              r2_vld;
    logic [DATA_W-1:0] r2_dvd, r2_dvs;
    t_side             r2_side;
    t_side             n2_side;

    always_comb begin
        n2_side = r1_side;
        if (r1_mul) begin
            n2_side.res = r1_p0 + {r1_p1 + r1_p2, 32'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_dvd  <= r1_dvd;
        r2_dvs  <= r1_dvs;
        r2_side <= n2_side;
    end

    // Divider pipeline, carrying all other results alongside
    logic              d_vld;
    logic [DATA_W-1:0] d_quo, d_rem;
    t_side             d_side;

    sia_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r2_vld),
        .i_dividend (r2_dvd),
        .i_divisor  (r2_dvs),
        .i_side     (r2_side),
        .o_valid    (d_vld),
        .o_quo      (d_quo),
        .o_rem      (d_rem),
        .o_side     (d_side)
    );

    // Output stage: sign fix-up, zero-divisor override, width truncation
    logic [DATA_W-1:0] n_dres, n_out;

    always_comb begin
        n_dres = d_side.rem_sel ? d_rem : d_quo;
        if (d_side.neg) begin
            n_dres = DATA_W'(0) - n_dres;
        end
        if (d_side.dz) begin
            n_dres = '0;
        end
        n_out = (d_side.div_op ? n_dres : d_side.res) & width_mask(d_side.wsel);
    end

    logic              r_vld, r_dz;
    logic [DATA_W-1:0] r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= d_vld;
        end
        r_res <= n_out;
        r_dz  <= d_side.dz;
    end

    assign o_valid       = r_vld;
    assign o_result      = r_res;
    assign o_div_by_zero = r_dz;
endmodule
`default_nettype wire
